// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the speech segmenter.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/ssh_pkg.sv -----
// Package for the speech segmenter: beat types, config struct, register indexes.
// No dependencies; used by every module of the block.
package ssh_pkg;

   localparam int PROB_FIELD_BITS = 16;
   localparam int LEN_BITS        = 16;
   localparam int SEG_BITS        = 16;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [LEN_BITS-1:0] RUN_MAX = '1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ONSET_LEVEL     = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_LEVEL    = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_SPEECH_LEN  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_SILENCE_LEN = 8'd3;

   // Reset values
   localparam logic [PROB_FIELD_BITS-1:0] ONSET_RESET       = 16'd32768;
   localparam logic [PROB_FIELD_BITS-1:0] OFFSET_RESET      = 16'd32768;
   localparam logic [LEN_BITS-1:0]        MIN_SPEECH_RESET  = 16'd10;
   localparam logic [LEN_BITS-1:0]        MIN_SILENCE_RESET = 16'd5;

   typedef struct packed {
      logic [PROB_FIELD_BITS-1:0] frame_prob;
      logic                       final_frame;
   } req_type;

   typedef struct packed {
      logic [SEG_BITS-1:0] seg_start;
      logic [SEG_BITS-1:0] seg_end;
      logic                by_flush;
   } rsp_type;

   typedef struct packed {
      logic [PROB_FIELD_BITS-1:0] onset_level;
      logic [PROB_FIELD_BITS-1:0] offset_level;
      logic [LEN_BITS-1:0]        min_speech_len;
      logic [LEN_BITS-1:0]        min_silence_len;
   } cfg_type;

endpackage

// ----- rtl/core/ssh_csr.sv -----
// Configuration registers of the speech segmenter.
// Depends on ssh_pkg for the register indexes and the config struct.
module ssh_csr #(
   parameter int PROB_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [ssh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ssh_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output ssh_pkg::cfg_type                     cfg
);
   import ssh_pkg::*;

   localparam int PW = (PROB_BITS < PROB_FIELD_BITS) ? PROB_BITS : PROB_FIELD_BITS;
   localparam logic [PROB_FIELD_BITS-1:0] PROB_MASK =
      PROB_FIELD_BITS'((64'd1 << PW) - 64'd1);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode one write beat; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ONSET_LEVEL:     cfg_in.onset_level     = csr_wdata & PROB_MASK;
            REG_OFFSET_LEVEL:    cfg_in.offset_level    = csr_wdata & PROB_MASK;
            REG_MIN_SPEECH_LEN:  cfg_in.min_speech_len  = csr_wdata;
            REG_MIN_SILENCE_LEN: cfg_in.min_silence_len = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.onset_level     <= ONSET_RESET & PROB_MASK;
         cfg_ff.offset_level    <= OFFSET_RESET & PROB_MASK;
         cfg_ff.min_speech_len  <= MIN_SPEECH_RESET;
         cfg_ff.min_silence_len <= MIN_SILENCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ssh_decide.sv -----
// Per-frame decision logic: onset, offset counting, segment close and flush.
// Depends on ssh_pkg; purely combinational, state is held in the top level.
module ssh_decide #(
   parameter int INDEX_BITS = 16,
   parameter int PROB_BITS  = 16
) (
   input  ssh_pkg::cfg_type                 cfg,
   input  ssh_pkg::req_type                 item,
   input  logic                             voiced,
   input  logic [INDEX_BITS-1:0]            start_index,
   input  logic [ssh_pkg::LEN_BITS-1:0]     quiet_run,
   input  logic [INDEX_BITS-1:0]            frame_number,
   output logic                             voiced_next,
   output logic [INDEX_BITS-1:0]            start_next,
   output logic [ssh_pkg::LEN_BITS-1:0]     quiet_next,
   output logic [INDEX_BITS-1:0]            frame_next,
   output logic                             res_valid,
   output ssh_pkg::rsp_type                 res
);
   import ssh_pkg::*;

   localparam int EW = ((INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS) + 2;
   localparam int PW = (PROB_BITS < PROB_FIELD_BITS) ? PROB_BITS : PROB_FIELD_BITS;
   localparam logic [PROB_FIELD_BITS-1:0] PROB_MASK =
      PROB_FIELD_BITS'((64'd1 << PW) - 64'd1);
   localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

   logic [PROB_FIELD_BITS-1:0] prob;
   logic                       is_onset;
   logic                       is_quiet;
   logic [LEN_BITS-1:0]        quiet_inc;
   logic                       close_quiet;
   logic                       close_flush;
   logic                       open_mid;
   logic [INDEX_BITS-1:0]      start_mid;
   logic [LEN_BITS-1:0]        quiet_mid;
   logic [EW-1:0]              idx_ext;
   logic [EW-1:0]              run_ext;
   logic [EW-1:0]              st_ext;
   logic [EW-1:0]              end_ext;
   logic [EW-1:0]              span;

   always_comb begin
      prob     = item.frame_prob & PROB_MASK;
      is_onset = !voiced && (prob >= cfg.onset_level);
      is_quiet = voiced && (prob < cfg.offset_level);

      // Silent-run counter saturates
      quiet_inc   = (quiet_run == RUN_MAX) ? quiet_run : quiet_run + 16'd1;
      close_quiet = is_quiet && (quiet_inc >= cfg.min_silence_len);

      // Segment state after the onset/offset step, before the final-frame flush
      open_mid  = is_onset || (voiced && !close_quiet);
      start_mid = is_onset ? frame_number : start_index;
      priority if (is_onset)  quiet_mid = '0;
      else if (is_quiet)      quiet_mid = quiet_inc;
      else if (voiced)        quiet_mid = '0;
      else                    quiet_mid = quiet_run;

      close_flush = item.final_frame && open_mid;

      // Exclusive end: idx + 1 - run, clamped to [start, IDX_MAX]
      idx_ext = EW'(frame_number) + EW'(1);
      run_ext = EW'(quiet_mid);
      st_ext  = EW'(start_mid);
      if (idx_ext <= run_ext + st_ext) end_ext = st_ext;
      else                             end_ext = idx_ext - run_ext;
      if (end_ext > EW'(IDX_MAX)) end_ext = EW'(IDX_MAX);
      span = end_ext - st_ext;

      res_valid     = (close_quiet || close_flush) && (span >= EW'(cfg.min_speech_len));
      res.seg_start = st_ext[SEG_BITS-1:0];
      res.seg_end   = end_ext[SEG_BITS-1:0];
      res.by_flush  = close_flush;

      // Next state; the last frame clears everything
      if (item.final_frame) begin
         voiced_next = 1'b0;
         start_next  = '0;
         quiet_next  = '0;
         frame_next  = '0;
      end else begin
         voiced_next = open_mid;
         start_next  = start_mid;
         quiet_next  = close_quiet ? '0 : quiet_mid;
         frame_next  = (frame_number == IDX_MAX) ? IDX_MAX : frame_number + 1'b1;
      end
   end

endmodule

// ----- rtl/core/speech_segment_hysteresis.sv -----
// Top level of the hysteresis speech segmenter.
// Depends on ssh_pkg, ssh_csr, ssh_decide and assert_macros.svh.
//
// Usage:
//   req channel: one beat per frame (frame_prob in Q0.16, final_frame marks
//   the last frame of a sequence). A beat is taken when req_valid is high and
//   req_stall is low.
//   rsp channel: at most one beat per frame, a closed speech segment
//   [seg_start, seg_end) with by_flush set if the last frame closed it.
//   csr channel: register writes by index (0 onset, 1 offset, 2 minimum
//   speech length, 3 minimum silence length); csr_ready is always high and
//   unknown indexes are ignored. Write only while no frame is in flight.
// Timing: a frame is held in the input register, its decision is made
//   by the logic between that register and the result register, and a result
//   shows on rsp from there. One frame per cycle is sustained while rsp_stall
//   is low; the segment state updates in the same cycle as the decision.
// Stall: when rsp_stall holds a result, a frame in the input register waits
//   and req_stall rises; frames that produce no result still need that slot.
// Reset: synchronous, active high; clears the segment state, the frame counter,
//   the valid flags of both beat registers and loads the register defaults.
`include "assert_macros.svh"

module speech_segment_hysteresis #(
   parameter int INDEX_BITS = 16,
   parameter int PROB_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ssh_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ssh_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ssh_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ssh_pkg::*;

   cfg_type                 cfg;

   // Input register
   logic                    s1_valid_ff, s1_valid_in;
   req_type                 s1_item_ff;
   logic                    req_take;
   logic                    s1_advance;

   // Segment state
   logic                    voiced_ff, voiced_in;
   logic [INDEX_BITS-1:0]   start_index_ff, start_index_in;
   logic [LEN_BITS-1:0]     quiet_run_ff, quiet_run_in;
   logic [INDEX_BITS-1:0]   frame_ff, frame_in;

   // Result register
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_beat_ff;
   logic                    res_valid;
   rsp_type                 res;

   // Check terms
   logic                    final_step;
   logic                    state_clear;

   assign csr_ready = 1'b1;

   ssh_csr #(
      .PROB_BITS (PROB_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssh_decide #(
      .INDEX_BITS (INDEX_BITS),
      .PROB_BITS  (PROB_BITS)
   ) u_decide (
      .cfg            (cfg),
      .item           (s1_item_ff),
      .voiced         (voiced_ff),
      .start_index    (start_index_ff),
      .quiet_run      (quiet_run_ff),
      .frame_number   (frame_ff),
      .voiced_next    (voiced_in),
      .start_next     (start_index_in),
      .quiet_next     (quiet_run_in),
      .frame_next     (frame_in),
      .res_valid      (res_valid),
      .res            (res)
   );

   // Handshake: frame moves on when the result slot is free or being drained
   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)        s1_valid_in = 1'b1;
      else if (s1_advance) s1_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance && res_valid)      out_valid_in = 1'b1;
      else if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         voiced_ff      <= 1'b0;
         start_index_ff <= '0;
         quiet_run_ff   <= '0;
         frame_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_advance) begin
            voiced_ff      <= voiced_in;
            start_index_ff <= start_index_in;
            quiet_run_ff   <= quiet_run_in;
            frame_ff       <= frame_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) s1_item_ff <= req_payload;
      if (s1_advance && res_valid) out_beat_ff <= res;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   // Checks
   assign final_step  = s1_advance && s1_item_ff.final_frame;
   assign state_clear = !voiced_ff && frame_ff == '0 && quiet_run_ff == '0;

   `ASSERT_NEXT(a_final_clears, clock, reset, final_step, state_clear)
   `ASSERT_IMPLY(a_idle_no_run, clock, reset, !voiced_ff, quiet_run_ff == '0)
   `ASSERT_IMPLY(a_start_not_ahead, clock, reset, voiced_ff, start_index_ff <= frame_ff)

endmodule
